// ----- hw/rtl/rrts_pkg.sv -----
// rrts_pkg: shared types, codes and defaults for the round-robin thread scheduler.
// No dependencies; imported by rrts_ctrl, rrts_dp and the top level.
`default_nettype none

package rrts_pkg;

  localparam int MAX_THREADS_DEF = 16;
  localparam int SCAN_LANES      = 4;    // slots examined per scan cycle

  localparam int MODE_W      = 3;
  localparam int ID_FIELD_W  = 4;
  localparam int STATUS_W    = 3;
  localparam int QUANTUM_W   = 16;
  localparam int IN_DATA_W   = 8;
  localparam int IN_USER_W   = 8;
  localparam int OUT_DATA_W  = 16;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd5;

  // register index (paddr[2])
  localparam logic REG_QUANTUM = 1'b0;

  // event codes
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CREATE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EXIT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_YIELD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SLEEP  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_WAKEUP = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STS_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NONE_READY = 3'd2;
  localparam logic [STATUS_W-1:0] STS_ALL_EXITED = 3'd3;
  localparam logic [STATUS_W-1:0] STS_BAD_TARGET = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;   // latch incoming event word
    logic eval;      // apply the event's direct updates
    logic scan;      // run one scan step
    logic load_out;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic need_scan;  // valid in EVAL
    logic scan_done;  // valid in SCAN: hit or last step
  } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rrts_ctrl.sv -----
// rrts_ctrl: sequencing state machine and output valid flag.
// Depends on rrts_pkg (state_t, cmd_t, stat_t).
`default_nettype none

module rrts_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  wire            m_tready,
  input  wire rrts_pkg::stat_t stat,
  output rrts_pkg::cmd_t  cmd
);
  import rrts_pkg::*;

  state_t state, state_next;
  logic   out_valid;
  logic   out_free;

  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = stat.need_scan ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == ST_IDLE);
    cmd.capture  = (state == ST_IDLE) && s_tvalid;
    cmd.eval     = (state == ST_EVAL);
    cmd.scan     = (state == ST_SCAN);
    cmd.load_out = (state == ST_FINISH) && out_free;
    m_tvalid     = out_valid;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rrts_dp.sv -----
// rrts_dp: slot tables, quantum counter, round-robin / lowest-free scanner, result regs.
// Depends on rrts_pkg; driven by rrts_ctrl commands.
`default_nettype none

module rrts_dp #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire rrts_pkg::cmd_t                 cmd,
  output rrts_pkg::stat_t                     stat,
  input  wire [rrts_pkg::MODE_W-1:0]          mode,
  input  wire [rrts_pkg::ID_FIELD_W-1:0]      target_id,
  input  wire [rrts_pkg::QUANTUM_W-1:0]       quantum_ticks,
  output logic [rrts_pkg::OUT_DATA_W-1:0]     out_word
);
  import rrts_pkg::*;

  localparam int ID_W   = $clog2(MAX_THREADS);
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);
  localparam int STEPS  = (MAX_THREADS + SCAN_LANES - 1) / SCAN_LANES;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int OFF_W  = $clog2(STEPS * SCAN_LANES);
  localparam int SUM_W  = $clog2(2 * MAX_THREADS + SCAN_LANES);

  // slot tables: running slot is cur when run_flag is set
  logic [MAX_THREADS-1:0] ready_vec;
  logic [MAX_THREADS-1:0] sleep_vec;
  logic [MAX_THREADS-1:0] never_ran;
  logic [ID_W-1:0]        cur;
  logic                   run_flag;
  logic [CNT_W-1:0]       live_count;
  logic [QUANTUM_W-1:0]   ticks_left;
  logic                   halted;

  // per-event working regs
  logic [MODE_W-1:0]      mode_q;
  logic [ID_FIELD_W-1:0]  target_q;
  logic                   had_run_q;
  logic                   kind_create;
  logic [ID_W-1:0]        scan_base;
  logic [STEP_W-1:0]      scan_step;
  logic [STATUS_W-1:0]    res_status;
  logic [ID_FIELD_W-1:0]  res_created;
  logic                   res_sw;
  logic                   res_fr;

  logic                   tick_expire;
  logic                   last_live;
  logic                   tgt_ok;
  logic [ID_W-1:0]        tgt_idx;
  logic [ID_W-1:0]        cur_plus1;
  logic [STATUS_W-1:0]    eval_status;
  logic                   hit;
  logic [ID_W-1:0]        hit_idx;
  logic                   last_step;
  logic                   change;

  assign tick_expire = (ticks_left <= QUANTUM_W'(1));
  assign last_live   = (live_count <= CNT_W'(1));
  assign tgt_ok      = (int'(target_q) < MAX_THREADS);
  assign tgt_idx     = ID_W'(target_q);
  assign cur_plus1   = (cur == ID_W'(MAX_THREADS - 1)) ? '0 : cur + 1'b1;
  assign last_step   = (scan_step == STEP_W'(STEPS - 1));
  assign change      = (hit_idx != cur) || !had_run_q;

  always_comb begin
    eval_status = STS_OK;
    if (halted) begin
      eval_status = STS_ALL_EXITED;
    end else if (mode_q == MODE_EXIT && run_flag && last_live) begin
      eval_status = STS_ALL_EXITED;
    end else if (mode_q == MODE_WAKEUP) begin
      if (!tgt_ok) begin
        eval_status = STS_BAD_TARGET;
      end else if (!ready_vec[tgt_idx] && !sleep_vec[tgt_idx] &&
                   !(run_flag && cur == tgt_idx)) begin
        eval_status = STS_BAD_TARGET;
      end
    end
  end

  always_comb begin
    stat.need_scan = 1'b0;
    if (!halted) begin
      case (mode_q)
        MODE_TICK:   stat.need_scan = tick_expire;
        MODE_CREATE: stat.need_scan = 1'b1;
        MODE_EXIT:   stat.need_scan = !(run_flag && last_live);
        MODE_YIELD:  stat.need_scan = 1'b1;
        MODE_SLEEP:  stat.need_scan = 1'b1;
        default:     stat.need_scan = 1'b0;
      endcase
    end
    stat.scan_done = hit || last_step;
  end

  // scanner: SCAN_LANES slots per cycle, lowest lane wins
  always_comb begin
    logic [OFF_W-1:0] off;
    logic [SUM_W-1:0] sum;
    logic [ID_W-1:0]  idx;
    logic             match;
    hit     = 1'b0;
    hit_idx = '0;
    match   = 1'b0;
    for (int j = SCAN_LANES - 1; j >= 0; j--) begin
      off = OFF_W'(int'(scan_step) * SCAN_LANES + j);
      sum = SUM_W'(scan_base) + SUM_W'(off);
      idx = (sum >= SUM_W'(MAX_THREADS)) ? ID_W'(sum - SUM_W'(MAX_THREADS)) : ID_W'(sum);
      match = 1'b0;
      if (int'(off) < MAX_THREADS) begin
        if (kind_create) begin
          match = !ready_vec[idx] && !sleep_vec[idx] && !(run_flag && cur == idx);
        end else begin
          match = ready_vec[idx];
        end
        if (match) begin
          hit     = 1'b1;
          hit_idx = idx;
        end
      end
    end
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_vec  <= '0;
      sleep_vec  <= '0;
      never_ran  <= '0;
      cur        <= '0;
      run_flag   <= 1'b1;
      live_count <= CNT_W'(1);
      ticks_left <= QUANTUM_RESET;
      halted     <= 1'b0;
    end else begin
      if (cmd.eval && !halted) begin
        case (mode_q)
          MODE_TICK: begin
            if (tick_expire) begin
              if (run_flag) begin
                ready_vec[cur] <= 1'b1;
                run_flag       <= 1'b0;
              end
            end else begin
              ticks_left <= ticks_left - 1'b1;
            end
          end
          MODE_EXIT: begin
            if (run_flag) begin
              run_flag       <= 1'b0;
              never_ran[cur] <= 1'b0;
              if (live_count != '0) live_count <= live_count - 1'b1;
              if (last_live) halted <= 1'b1;
            end
          end
          MODE_YIELD: begin
            if (run_flag) begin
              ready_vec[cur] <= 1'b1;
              run_flag       <= 1'b0;
            end
          end
          MODE_SLEEP: begin
            if (run_flag) begin
              sleep_vec[cur] <= 1'b1;
              run_flag       <= 1'b0;
            end
          end
          MODE_WAKEUP: begin
            if (tgt_ok && sleep_vec[tgt_idx]) begin
              sleep_vec[tgt_idx] <= 1'b0;
              ready_vec[tgt_idx] <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.scan) begin
        if (hit) begin
          ticks_left <= quantum_ticks;
          if (kind_create) begin
            ready_vec[hit_idx] <= 1'b1;
            never_ran[hit_idx] <= 1'b1;
            live_count         <= live_count + 1'b1;
          end else begin
            ready_vec[hit_idx] <= 1'b0;
            run_flag           <= 1'b1;
            cur                <= hit_idx;
            if (change) never_ran[hit_idx] <= 1'b0;
          end
        end else if (last_step && !kind_create) begin
          ticks_left <= quantum_ticks;
        end
      end
    end
  end

  // event and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= mode;
      target_q <= target_id;
    end
    if (cmd.eval) begin
      had_run_q   <= run_flag;
      kind_create <= (mode_q == MODE_CREATE);
      scan_base   <= (mode_q == MODE_CREATE) ? '0 : cur_plus1;
      scan_step   <= '0;
      res_status  <= eval_status;
      res_created <= '0;
      res_sw      <= 1'b0;
      res_fr      <= 1'b0;
    end
    if (cmd.scan) begin
      scan_step <= scan_step + 1'b1;
      if (hit) begin
        res_status <= STS_OK;
        if (kind_create) begin
          res_created <= ID_FIELD_W'(hit_idx);
        end else if (change) begin
          res_sw <= 1'b1;
          res_fr <= never_ran[hit_idx];
        end
      end else if (last_step) begin
        res_status <= kind_create ? STS_FULL : STS_NONE_READY;
      end
    end
    if (cmd.load_out) begin
      out_word <= {3'b000, res_fr, res_sw, res_created, ID_FIELD_W'(cur), res_status};
    end
  end

  a_ready_sleep_disjoint: assert property (@(posedge clk) disable iff (rst)
    (ready_vec & sleep_vec) == '0)
    else $error("slot both runnable and sleeping");

  a_running_slot_clean: assert property (@(posedge clk) disable iff (rst)
    run_flag |-> (!ready_vec[cur] && !sleep_vec[cur]))
    else $error("running slot also marked runnable or sleeping");

  a_halted_empty: assert property (@(posedge clk) disable iff (rst)
    halted |-> (!run_flag && live_count == '0))
    else $error("halted with a live or running thread");

  a_dispatch_runs: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && hit && !kind_create) |=> run_flag)
    else $error("dispatch did not leave a running slot");

endmodule

`default_nettype wire

// ----- hw/rtl/round_robin_thread_scheduler_top.sv -----
// round_robin_thread_scheduler_top: event stream in, scheduling result stream out,
// quantum register on an APB-style port. Depends on rrts_pkg, rrts_ctrl, rrts_dp.
//
//  channel   dir  handshake              word
//  s_*       in   s_tvalid / s_tready    tdata: target_id[3:0]; tuser: mode[2:0]
//  m_*       out  m_tvalid / m_tready    tdata: status, running_id, created_id,
//                                        switched, first_run
//  apb       in   psel & penable         reg 0 at 0x0: quantum_ticks[15:0]
//
// One event is in flight at a time. Events with no slot search pass through
// accept, evaluate and finish; create, exit, yield, sleep and an expiring tick
// add a scan between evaluate and finish, four slots per cycle, until a hit or
// the last step. No scan runs once halted or when an exit ends the last thread.
// Reset (rst, synchronous) leaves slot 0 running, quantum 5; no clearing pass.
// A result waits in the output register while the next event is taken; the
// finish step stalls only if that register is still full.
`default_nettype none

module round_robin_thread_scheduler_top #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  // event stream
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire [rrts_pkg::IN_DATA_W-1:0]    s_tdata,  // [3:0] target_id, rest zero
  input  wire [rrts_pkg::IN_USER_W-1:0]    s_tuser,  // [2:0] mode, rest zero
  // result stream
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [rrts_pkg::OUT_DATA_W-1:0]  m_tdata,  // [2:0] status, [6:3] running_id,
                                                     // [10:7] created_id, [11] switched,
                                                     // [12] first_run, rest zero
  // configuration
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [rrts_pkg::PADDR_W-1:0]      paddr,
  input  wire [rrts_pkg::PDATA_W-1:0]      pwdata,
  output logic [rrts_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import rrts_pkg::*;

  cmd_t                 cmd;
  stat_t                stat;
  logic [QUANTUM_W-1:0] quantum_ticks;
  logic                 cfg_write;

  // register select is paddr[2]; low bits are byte offsets within the word
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_ticks <= QUANTUM_RESET;
    end else if (cfg_write && paddr[2] == REG_QUANTUM) begin
      quantum_ticks <= pwdata[QUANTUM_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_QUANTUM) begin
      prdata = PDATA_W'(quantum_ticks);
    end
  end

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrts_dp #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (s_tuser[MODE_W-1:0]),
    .target_id     (s_tdata[ID_FIELD_W-1:0]),
    .quantum_ticks (quantum_ticks),
    .out_word      (m_tdata)
  );

endmodule

`default_nettype wire

// ----- bench/tb_round_robin_thread_scheduler_top.sv -----
// Self-checking bench for round_robin_thread_scheduler_top: event words in, result words out,
// quantum register on the APB port. A scoreboard class predicts every result word.
// Depends on rrts_pkg and the scheduler RTL only.
module tb_round_robin_thread_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  localparam int NSLOT        = MAX_THREADS_DEF;
  localparam int IDLE_PCT     = 37;    // chance per cycle that a side idles
  localparam int DRAIN_CYCLES = 12;    // covers the longest event, with margin on top
  localparam int STALL_LIMIT  = 2000;  // cycles with no word moving anywhere
  localparam int PHASE_EVENTS = 240;

  // reserved event codes: the block must answer them without touching state
  localparam logic [MODE_W-1:0]  MODE_RSVD6    = 3'd6;
  localparam logic [MODE_W-1:0]  MODE_RSVD7    = 3'd7;
  localparam logic [PADDR_W-1:0] ADDR_QUANTUM  = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

  typedef enum logic [1:0] {SLOT_FREE, SLOT_READY, SLOT_RUN, SLOT_SLEEP} slot_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [ID_FIELD_W-1:0] running_id;
    logic [ID_FIELD_W-1:0] created_id;
    logic                  switched;
    logic                  first_run;
  } sched_result_t;

  // Slot table mirror plus the queue of result words still owed by the block.
  class sched_checker;
    slot_t                slots [NSLOT];
    bit                   never_ran [NSLOT];
    int unsigned          cur;
    int unsigned          live;
    int unsigned          ticks_left;
    bit                   halted;
    logic [QUANTUM_W-1:0] quantum;
    sched_result_t        due_results [$];
    int unsigned          errors;
    int unsigned          checked;
    int unsigned          events;
    int unsigned          status_seen [8];

    function new();
      int i;
      for (i = 0; i < NSLOT; i++) begin
        slots[i]     = SLOT_FREE;
        never_ran[i] = 1'b0;
      end
      for (i = 0; i < 8; i++) status_seen[i] = 0;
      slots[0]   = SLOT_RUN;
      cur        = 0;
      live       = 1;
      quantum    = QUANTUM_RESET;
      ticks_left = QUANTUM_RESET;
      halted     = 1'b0;
      errors     = 0;
      checked    = 0;
      events     = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Round-robin search starting after cur, ending with cur itself.
    function logic [STATUS_W-1:0] rotate_to_next(bit had_run, output bit sw, output bit fr);
      int k;
      int idx;
      sw = 1'b0;
      fr = 1'b0;
      ticks_left = quantum;
      for (k = 1; k <= NSLOT; k++) begin
        idx = (cur + k) % NSLOT;
        if (slots[idx] == SLOT_READY) begin
          slots[idx] = SLOT_RUN;
          if (idx != cur || !had_run) begin
            sw            = 1'b1;
            fr            = never_ran[idx];
            never_ran[idx] = 1'b0;
          end
          cur = idx;
          return STS_OK;
        end
      end
      return STS_NONE_READY;
    endfunction

    // Called at the edge an event word is accepted.
    function void post_event(logic [MODE_W-1:0] mode, logic [ID_FIELD_W-1:0] target);
      sched_result_t r;
      bit            had_run;
      bit            sw;
      bit            fr;
      int            i;
      r       = '0;
      sw      = 1'b0;
      fr      = 1'b0;
      had_run = (slots[cur] == SLOT_RUN);
      if (halted) begin
        r.status = STS_ALL_EXITED;
      end else begin
        case (mode)
          MODE_TICK: begin
            if (ticks_left <= 1) begin
              if (had_run) slots[cur] = SLOT_READY;
              r.status = rotate_to_next(had_run, sw, fr);
            end else begin
              ticks_left--;
            end
          end
          MODE_CREATE: begin
            r.status = STS_FULL;
            for (i = 0; i < NSLOT; i++) begin
              if (slots[i] == SLOT_FREE) begin
                slots[i]     = SLOT_READY;
                never_ran[i] = 1'b1;
                live++;
                r.created_id = ID_FIELD_W'(i);
                r.status     = STS_OK;
                ticks_left   = quantum;
                break;
              end
            end
          end
          MODE_EXIT: begin
            if (had_run) begin
              slots[cur]     = SLOT_FREE;
              never_ran[cur] = 1'b0;
              if (live > 0) live--;
            end
            if (had_run && live == 0) begin
              halted   = 1'b1;
              r.status = STS_ALL_EXITED;
            end else begin
              r.status = rotate_to_next(had_run, sw, fr);
            end
          end
          MODE_YIELD: begin
            if (had_run) slots[cur] = SLOT_READY;
            r.status = rotate_to_next(had_run, sw, fr);
          end
          MODE_SLEEP: begin
            if (had_run) slots[cur] = SLOT_SLEEP;
            r.status = rotate_to_next(had_run, sw, fr);
          end
          MODE_WAKEUP: begin
            if (slots[target] == SLOT_FREE) r.status = STS_BAD_TARGET;
            else if (slots[target] == SLOT_SLEEP) slots[target] = SLOT_READY;
          end
          default: ;
        endcase
      end
      r.running_id = ID_FIELD_W'(cur);
      r.switched   = sw;
      r.first_run  = fr;
      status_seen[r.status]++;
      events++;
      due_results.push_back(r);
    endfunction

    // Called at the edge a result word is accepted.
    task check_result(logic [OUT_DATA_W-1:0] word);
      sched_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result word %h with nothing outstanding", word));
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (word[2:0] !== want.status || word[6:3] !== want.running_id ||
          word[10:7] !== want.created_id || word[11] !== want.switched ||
          word[12] !== want.first_run)
        report($sformatf({"result %0d: sts %0d run %0d new %0d sw %b fr %b,",
                          " want sts %0d run %0d new %0d sw %b fr %b"},
                         checked, word[2:0], word[6:3], word[10:7], word[11], word[12],
                         want.status, want.running_id, want.created_id, want.switched,
                         want.first_run));
    endtask
  endclass

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata  = '0;    // [3:0] target_id
  logic [IN_USER_W-1:0]   s_tuser  = '0;    // [2:0] mode
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;          // [2:0] status, [6:3] running_id,
                                            // [10:7] created_id, [11] switched, [12] first_run
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [PADDR_W-1:0]     paddr    = '0;
  logic [PDATA_W-1:0]     pwdata   = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  bit                     steady   = 1'b0;  // no idling on either side while set
  int unsigned            quiet_cycles = 0;
  sched_checker           sched_sb;

  round_robin_thread_scheduler_top #(.MAX_THREADS(NSLOT)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // Result side: random backpressure, checked at the rising edge.
  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sched_sb.check_result(m_tdata);
  end

  // Watchdog: any accepted word on any port restarts the count.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               quiet_cycles, sched_sb.due_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One event word; entered and left at a falling edge. valid stays high
  // between back-to-back words, only a random gap drops it.
  task automatic send_event(input logic [MODE_W-1:0] mode,
                            input logic [ID_FIELD_W-1:0] target);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W-ID_FIELD_W){1'b0}}, target};
    s_tuser  <= {{(IN_USER_W-MODE_W){1'b0}}, mode};
    do @(posedge clk); while (!s_tready);
    sched_sb.post_event(mode, target);
    @(negedge clk);
  endtask

  // Hold off the event stream until every owed result is out, then let the
  // block settle before touching the register.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sched_sb.due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic check_quantum_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_QUANTUM;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(sched_sb.quantum))
      sched_sb.report($sformatf("quantum readback %h, want %h", prdata, sched_sb.quantum));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write then read back; upper data bits carry junk the register must drop.
  task automatic program_quantum(input logic [PADDR_W-1:0] addr,
                                 input logic [QUANTUM_W-1:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_QUANTUM) sched_sb.quantum = value;
    @(negedge clk);
    check_quantum_reg();
  endtask

  function automatic int pick_sleeper();
    int found [$];
    int i;
    for (i = 0; i < NSLOT; i++)
      if (sched_sb.slots[i] == SLOT_SLEEP) found.push_back(i);
    if (found.size() == 0) return -1;
    return found[$urandom_range(found.size() - 1)];
  endfunction

  // Mostly legal traffic steered by the mirrored slot table: wakeups usually
  // hit a sleeper, exits never end the run early. Reserved codes are noise.
  task automatic send_random_event(input int create_w, output bit counted);
    int                    r;
    int                    sl;
    logic [MODE_W-1:0]     mode;
    logic [ID_FIELD_W-1:0] target;
    r       = $urandom_range(99);
    target  = ID_FIELD_W'($urandom);
    counted = 1'b1;
    if (r < 8) begin
      mode    = $urandom_range(1) ? MODE_RSVD7 : MODE_RSVD6;
      counted = 1'b0;
    end else if (r < 8 + create_w) begin
      mode = MODE_CREATE;
    end else begin
      r = $urandom_range(99);
      if (r < 30) mode = MODE_TICK;
      else if (r < 48) mode = MODE_YIELD;
      else if (r < 63) mode = MODE_SLEEP;
      else if (r < 85) begin
        mode = MODE_WAKEUP;
        sl   = pick_sleeper();
        if (sl >= 0 && $urandom_range(9) < 7) target = ID_FIELD_W'(sl);
      end else if (sched_sb.slots[sched_sb.cur] == SLOT_RUN && sched_sb.live == 1)
        mode = MODE_CREATE;
      else
        mode = MODE_EXIT;
    end
    send_event(mode, target);
  endtask

  initial begin : stimulus
    int unsigned plan [6];
    int          p;
    int          n;
    int          k;
    int          sl;
    int          create_w;
    bit          counted;

    sched_sb = new();
    plan     = '{1, 0, 65535, 2, 3, 5};
    plan[5]  = $urandom_range(4, 40);
    create_w = 10;

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    check_quantum_reg();  // reset value

    // Directed walk from the reset table (slot 0 running, quantum 5).
    send_event(MODE_TICK,   4'd0);   // plain countdown
    send_event(MODE_WAKEUP, 4'd15);  // free slot -> bad target
    send_event(MODE_WAKEUP, 4'd0);   // running slot -> no change
    send_event(MODE_CREATE, 4'd15);  // slot 1
    send_event(MODE_CREATE, 4'd0);   // slot 2
    send_event(MODE_WAKEUP, 4'd1);   // runnable slot -> no change
    send_event(MODE_YIELD,  4'd15);  // to 1, first run
    send_event(MODE_SLEEP,  4'd0);   // to 2, first run
    send_event(MODE_WAKEUP, 4'd1);   // sleeper back to runnable
    send_event(MODE_EXIT,   4'd15);  // frees 2, search wraps to 0
    send_event(MODE_RSVD6,  4'd15);
    send_event(MODE_RSVD7,  4'd0);
    send_event(MODE_SLEEP,  4'd0);   // to 1
    send_event(MODE_SLEEP,  4'd15);  // nothing runnable: processor idle
    send_event(MODE_TICK,   4'd0);   // idle tick only counts down
    send_event(MODE_YIELD,  4'd0);   // idle yield searches again, still none
    send_event(MODE_WAKEUP, 4'd0);
    send_event(MODE_EXIT,   4'd15);  // idle exit frees nothing, picks 0
    for (k = 0; k < 5; k++)
      send_event(MODE_TICK, 4'd15);  // last one expires, same slot resumes
    send_event(MODE_CREATE, 4'd0);   // lowest free slot is 2 again

    // Random phases, one quantum setting each. The first phase also pokes an
    // unmapped register address, which must leave the quantum alone.
    for (p = 0; p < 6; p++) begin
      if (p == 0) program_quantum(ADDR_UNMAPPED, 16'hBEEF);
      program_quantum(ADDR_QUANTUM, QUANTUM_W'(plan[p]));
      steady = (p == 2);
      if (plan[p] == 0) begin
        // zero quantum phase opens by filling the table and overflowing it
        while (sched_sb.live < NSLOT) send_event(MODE_CREATE, ID_FIELD_W'($urandom));
        send_event(MODE_CREATE, 4'd0);
        send_event(MODE_CREATE, 4'd15);
      end
      n = 0;
      while (n < PHASE_EVENTS) begin
        if (n % 40 == 0) create_w = $urandom_range(4, 30);
        if (p == 3 && n == PHASE_EVENTS / 2) wait_drained();
        send_random_event(create_w, counted);
        if (counted) n++;
      end
    end
    steady = 1'b0;

    // Wind down: wake every sleeper and exit until the last thread is gone,
    // then show that every code is answered with all-exited.
    for (k = 0; k < 4 * NSLOT && !sched_sb.halted; k++) begin
      sl = pick_sleeper();
      if (sl >= 0) send_event(MODE_WAKEUP, ID_FIELD_W'(sl));
      else send_event(MODE_EXIT, ID_FIELD_W'($urandom));
    end
    for (k = 0; k < 8; k++) send_event(MODE_W'(k), ID_FIELD_W'($urandom));

    s_tvalid <= 1'b0;
    while (sched_sb.due_results.size() != 0) @(negedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d events, %0d result words, quantum settings 1 0 65535 2 3 %0d",
             sched_sb.events, sched_sb.checked, plan[5]);
    $display("status mix: ok %0d, full %0d, none runnable %0d, all exited %0d, bad target %0d",
             sched_sb.status_seen[STS_OK], sched_sb.status_seen[STS_FULL],
             sched_sb.status_seen[STS_NONE_READY], sched_sb.status_seen[STS_ALL_EXITED],
             sched_sb.status_seen[STS_BAD_TARGET]);
    if (sched_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
